// ===== sv/bitmap_block_allocator_macros.svh =====
// Assertion macros shared by the bitmap block allocator modules.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BBA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the block allocator.
`default_nettype none

package bba_pkg;

   // Field widths
   localparam int OP_W       = 2;
   localparam int LEN_W      = 24;
   localparam int BLK_CNT_W  = 7;
   localparam int BLK_IDX_W  = 6;
   localparam int STATUS_W   = 2;
   localparam int BSIZE_W    = 16;
   localparam int NEED_W     = LEN_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'b1;
   localparam logic [BSIZE_W-1:0]   BLOCK_SIZE_RESET    = 16'd64;
   localparam logic [BLK_CNT_W-1:0] BLOCKS_IN_USE_RESET = 7'd64;

   // Divider: one quotient bit per step
   localparam int DIV_STEPS  = LEN_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC_BYTES  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_BLOCKS = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE         = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FREED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTHING = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic                load;
      logic                div_step;
      logic                div_round;
      logic                count_step;
      logic                ptr_clear;
      logic                grant_step;
      logic                reply;
      logic [STATUS_W-1:0] reply_status;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] req_op;
      logic            div_last;
      logic            count_done;
      logic            needed_zero;
      logic            enough;
      logic            slot_free;
      logic            grant_final;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/bba_ctrl.sv =====
// Sequencer of the block allocator: divide, round, count, decide, grant and reply phases.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bba_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire bba_pkg::sts_type sts,
   output bba_pkg::cmd_type     cmd
);
   import bba_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIVIDE = 3'd1;
   localparam logic [2:0] S_ROUND  = 3'd2;
   localparam logic [2:0] S_COUNT  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_GRANT  = 3'd5;
   localparam logic [2:0] S_REPLY  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] reply_status_ff, reply_status_in;

   // Take a new transaction only between operations
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in         = state_ff;
      reply_status_in  = reply_status_ff;
      cmd              = '0;
      cmd.reply_status = reply_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (sts.req_op)
                  OP_ALLOC_BYTES:  state_in = S_DIVIDE;
                  OP_ALLOC_BLOCKS: state_in = S_COUNT;
                  OP_FREE: begin
                     state_in        = S_REPLY;
                     reply_status_in = ST_FREED;
                  end
                  default:         state_in = S_IDLE;
               endcase
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.div_round = 1'b1;
            state_in      = S_COUNT;
         end
         S_COUNT: begin
            if (sts.count_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.count_step = 1'b1;
            end
         end
         S_DECIDE: begin
            priority if (sts.needed_zero) begin
               state_in        = S_REPLY;
               reply_status_in = ST_NOTHING;
            end else if (!sts.enough) begin
               state_in        = S_REPLY;
               reply_status_in = ST_NOSPACE;
            end else begin
               cmd.ptr_clear = 1'b1;
               state_in      = S_GRANT;
            end
         end
         S_GRANT: begin
            cmd.grant_step = 1'b1;
            if (sts.slot_free && sts.grant_final) state_in = S_IDLE;
         end
         S_REPLY: begin
            if (sts.slot_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         reply_status_ff <= ST_FREED;
      end else begin
         state_ff        <= state_in;
         reply_status_ff <= reply_status_in;
      end
   end

   `BBA_ASSERT_NEXT(a_div_to_round, state_ff == S_DIVIDE && sts.div_last, state_ff == S_ROUND, "divider did not finish after its last step")
   `BBA_ASSERT_NEXT(a_nospace_reply, state_ff == S_DECIDE && !sts.needed_zero && !sts.enough, state_ff == S_REPLY && reply_status_ff == ST_NOSPACE, "short allocation did not reply insufficient space")
   `BBA_ASSERT_NEXT(a_grant_end, state_ff == S_GRANT && sts.slot_free && sts.grant_final, state_ff == S_IDLE && !req_stall, "allocator did not return to idle after last grant")

endmodule

`default_nettype wire

// ===== sv/bba_dp.sv =====
// Datapath of the block allocator: used map, divider, scan counters, config and result register.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bba_dp #(
   parameter int NUM_BLOCKS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic [bba_pkg::OP_W-1:0]          req_operation,
   input  wire logic [bba_pkg::LEN_W-1:0]         req_byte_length,
   input  wire logic [bba_pkg::BLK_CNT_W-1:0]     req_block_count,
   input  wire logic [bba_pkg::BLK_IDX_W-1:0]     req_block_index,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic [bba_pkg::BLK_IDX_W-1:0]          rsp_block_number,
   output logic [bba_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                   rsp_last,
   input  wire bba_pkg::cmd_type                  cmd,
   output bba_pkg::sts_type                       sts
);
   import bba_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   // Configuration registers
   logic [BSIZE_W-1:0]   block_size_ff;
   logic [BLK_CNT_W-1:0] blocks_in_use_ff;

   // Operation registers
   logic [OP_W-1:0]      op_ff, op_in;
   logic [BLK_IDX_W-1:0] idx_ff, idx_in;
   logic [BSIZE_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]     dq_ff, dq_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [NEED_W-1:0]    needed_ff, needed_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [NUM_BLOCKS-1:0] map_ff, map_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BLK_IDX_W-1:0] rsp_number_ff, rsp_number_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BSIZE_W-1:0]   bs_eff;
   logic [BSIZE_W:0]     rem_sh;
   logic [BSIZE_W:0]     rem_diff;
   logic                 rem_ge;
   logic [CNT_W-1:0]     lim;
   logic [IDX_W-1:0]     ptr_idx;
   logic                 map_bit;
   logic                 slot_free;
   logic                 grant_go;
   logic                 grant_last;
   logic                 free_in_range;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff    <= BLOCK_SIZE_RESET;
         blocks_in_use_ff <= BLOCKS_IN_USE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:    block_size_ff    <= csr_data;
            CSR_BLOCKS_IN_USE: blocks_in_use_ff <= csr_data[BLK_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp block size and scan limit
   assign bs_eff = (block_size_ff == '0) ? BSIZE_W'(1) : block_size_ff;
   always_comb begin
      if (blocks_in_use_ff > BLK_CNT_W'(NUM_BLOCKS)) begin
         lim = CNT_W'(NUM_BLOCKS);
      end else begin
         lim = blocks_in_use_ff[CNT_W-1:0];
      end
   end

   // One restoring division step
   assign rem_sh   = {rem_ff, dq_ff[LEN_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, bs_eff});
   assign rem_diff = rem_sh - {1'b0, bs_eff};

   // Map bit under the scan pointer
   assign ptr_idx    = ptr_ff[IDX_W-1:0];
   assign map_bit    = map_ff[ptr_idx];
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign grant_go   = cmd.grant_step && slot_free;
   assign grant_last = ((NEED_W'(k_ff) + NEED_W'(1)) == needed_ff);
   assign free_in_range = (BLK_CNT_W'(idx_ff) < BLK_CNT_W'(NUM_BLOCKS));

   // Next values of the operation registers and the map
   always_comb begin
      op_in       = op_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      dq_in       = dq_ff;
      step_in     = step_ff;
      needed_in   = needed_ff;
      ptr_in      = ptr_ff;
      free_cnt_in = free_cnt_ff;
      k_in        = k_ff;
      map_in      = map_ff;

      if (cmd.load) begin
         op_in       = req_operation;
         idx_in      = req_block_index;
         rem_in      = '0;
         dq_in       = req_byte_length;
         step_in     = '0;
         needed_in   = NEED_W'(req_block_count);
         ptr_in      = '0;
         free_cnt_in = '0;
         k_in        = '0;
      end
      if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_diff[BSIZE_W-1:0] : rem_sh[BSIZE_W-1:0];
         dq_in   = {dq_ff[LEN_W-2:0], rem_ge};
         step_in = step_ff + 1'b1;
      end
      // round the quotient up when a remainder is left
      if (cmd.div_round) begin
         needed_in = NEED_W'(dq_ff) + NEED_W'(rem_ff != '0);
      end
      if (cmd.count_step && (ptr_ff < lim)) begin
         free_cnt_in = free_cnt_ff + CNT_W'(!map_bit);
         ptr_in      = ptr_ff + 1'b1;
      end
      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end
      if (grant_go) begin
         ptr_in = ptr_ff + 1'b1;
         if (!map_bit) begin
            map_in[ptr_idx] = 1'b1;
            k_in            = k_ff + 1'b1;
         end
      end
      // release one block on a free reply
      if (cmd.reply && (op_ff == OP_FREE) && free_in_range) begin
         map_in[idx_ff[IDX_W-1:0]] = 1'b0;
      end
   end

   // Next values of the result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      priority if (grant_go && !map_bit) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = BLK_IDX_W'(ptr_idx);
         rsp_status_in = ST_GRANTED;
         rsp_last_in   = grant_last;
      end else if (cmd.reply) begin
         rsp_valid_in  = 1'b1;
         rsp_number_in = (cmd.reply_status == ST_FREED) ? idx_ff : '0;
         rsp_status_in = cmd.reply_status;
         rsp_last_in   = 1'b1;
      end
   end

   // Hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         ptr_ff       <= '0;
         free_cnt_ff  <= '0;
         k_ff         <= '0;
         op_ff        <= OP_UNUSED;
      end else begin
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         ptr_ff       <= ptr_in;
         free_cnt_ff  <= free_cnt_in;
         k_ff         <= k_in;
         op_ff        <= op_in;
      end
   end

   // Hold payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      needed_ff     <= needed_in;
      rsp_number_ff <= rsp_number_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_number_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   // Status toward the controller
   always_comb begin
      sts.req_op      = req_operation;
      sts.div_last    = (step_ff == DIV_CNT_W'(DIV_STEPS - 1));
      sts.count_done  = (ptr_ff >= lim);
      sts.needed_zero = (needed_ff == '0);
      sts.enough      = (NEED_W'(free_cnt_ff) >= needed_ff);
      sts.slot_free   = slot_free;
      sts.grant_final = !map_bit && grant_last;
   end

   `BBA_ASSERT_SAME(a_grant_in_limit, grant_go, ptr_ff < lim, "grant scan ran past the scan limit")
   `BBA_ASSERT_SAME(a_single_is_last, rsp_valid_ff && rsp_status_ff != ST_GRANTED, rsp_last_ff, "single result without last")
   `BBA_ASSERT_NEXT(a_grant_counts, grant_go && !map_bit, k_ff == $past(k_ff) + 1'b1, "grant count did not advance")

endmodule

`default_nettype wire

// ===== sv/bitmap_block_allocator.sv =====
// Top level of the bitmap first-fit block allocator.
// Keeps one used bit per block (all free after reset) and serves one transaction at a time.
// A free transaction goes straight to its reply state. An allocate by block count first counts the free
// blocks one map bit per cycle (over blocks_in_use blocks, at most NUM_BLOCKS), then decides,
// then scans again one bit per cycle, emitting each granted block as it is found; the grant
// scan pauses while the result register is stalled. An allocate by bytes first runs the
// radix-2 divider, which turns the byte length into a block count rounded up. A zero-block
// or too-large request returns a single result after the counting pass. Configuration writes
// are always taken and must be issued only while no transaction is in progress.
`default_nettype none

module bitmap_block_allocator #(
   parameter int NUM_BLOCKS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bba_pkg::OP_W-1:0]          req_operation,
   input  wire logic [bba_pkg::LEN_W-1:0]         req_byte_length,
   input  wire logic [bba_pkg::BLK_CNT_W-1:0]     req_block_count,
   input  wire logic [bba_pkg::BLK_IDX_W-1:0]     req_block_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [bba_pkg::BLK_IDX_W-1:0]          rsp_block_number,
   output logic [bba_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                   rsp_last
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Accept every configuration write
   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_operation    (req_operation),
      .req_byte_length  (req_byte_length),
      .req_block_count  (req_block_count),
      .req_block_index  (req_block_index),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire
